### rtl/core/bs3_pkg.sv
// Package for the 3x3 box sum block: result record, field widths and constants.
// No dependencies; used by bs3_res_if and by box_sum_3x3_valid.
package bs3_pkg;

    // Fixed field widths of the result record and the width register
    localparam int SUM_OUT_BITS = 20;
    localparam int ROW_BITS     = 16;
    localparam int COL_OUT_BITS = 10;
    localparam int CFG_BITS     = 11;

    // Row counter saturation value and reset value of the width register
    localparam logic [ROW_BITS-1:0] ROW_MAX       = 16'hFFFF;
    localparam logic [CFG_BITS-1:0] WIDTH_DEFAULT = 11'd3;

    // Smallest image that still holds a full window, per side
    localparam logic [ROW_BITS-1:0] MIN_ROWS = 16'd3;

    // Output queue: three entries, two-bit pointers
    localparam int          QUEUE_DEPTH = 3;
    localparam logic [1:0]  QUEUE_LAST  = 2'd2;

    // One result transaction
    typedef struct packed {
        logic signed [SUM_OUT_BITS-1:0] window_sum;
        logic [ROW_BITS-1:0]            out_row;
        logic [COL_OUT_BITS-1:0]        out_col;
        logic                           done_res;
        logic [ROW_BITS-1:0]            complete_rows;
        logic                           size_error;
    } result_t;

endpackage

### rtl/core/bs3_if.sv
// Valid/ready channel interfaces for the 3x3 box sum block: pixel input and result output.
// Depends on bs3_pkg for the result field widths.
interface bs3_pix_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_value;
    logic                         end_of_image;

    modport source (output valid, output pixel_value, output end_of_image, input ready);
    modport sink   (input valid, input pixel_value, input end_of_image, output ready);
endinterface

interface bs3_res_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [bs3_pkg::SUM_OUT_BITS-1:0] window_sum;
    logic [bs3_pkg::ROW_BITS-1:0]            out_row;
    logic [bs3_pkg::COL_OUT_BITS-1:0]        out_col;
    logic                                    done_res;
    logic [bs3_pkg::ROW_BITS-1:0]            complete_rows;
    logic                                    size_error;

    modport source (output valid, output window_sum, output out_row, output out_col,
                    output done_res, output complete_rows, output size_error, input ready);
    modport sink   (input valid, input window_sum, input out_row, input out_col,
                    input done_res, input complete_rows, input size_error, output ready);
endinterface

### rtl/core/bs3_line_store.sv
// Two line stores (rows r-2 and r-1) in synchronous RAM with a registered read port.
// Forwards a write issued in the same cycle as a read of the same column. No dependencies.
module bs3_line_store #(
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_upper,
    input  logic [DATA_BITS-1:0] wr_middle,
    output logic [DATA_BITS-1:0] rd_upper,
    output logic [DATA_BITS-1:0] rd_middle
);

    logic [DATA_BITS-1:0] upper_mem [DEPTH];
    logic [DATA_BITS-1:0] middle_mem [DEPTH];

    logic [DATA_BITS-1:0] upper_q_reg;
    logic [DATA_BITS-1:0] middle_q_reg;
    logic [DATA_BITS-1:0] fwd_upper_reg;
    logic [DATA_BITS-1:0] fwd_middle_reg;
    logic                 fwd_hit_reg;
    logic                 fwd_hit_next;

    // Read and write collide on one column: RAM returns old data, so keep the new
    assign fwd_hit_next = wr_en && (wr_addr == rd_addr);

    // RAM write port, registered read port and forward data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
        if (rd_en)
        begin
            upper_q_reg    <= upper_mem[rd_addr];
            middle_q_reg   <= middle_mem[rd_addr];
            fwd_upper_reg  <= wr_upper;
            fwd_middle_reg <= wr_middle;
        end
    end

    // Forward select flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    assign rd_upper  = fwd_hit_reg ? fwd_upper_reg  : upper_q_reg;
    assign rd_middle = fwd_hit_reg ? fwd_middle_reg : middle_q_reg;

endmodule

### rtl/core/box_sum_3x3_valid.sv
// Streaming 3x3 box sum: top level with counters, window adder and output queue.
// Depends on bs3_pkg, bs3_if.sv (bs3_pix_if, bs3_res_if) and bs3_line_store.
//
// Usage:
//   pix_in carries one pixel per transaction in row-major order, or an end
//   item (end_of_image = 1) that closes the image. image_width is written
//   with image_width_we while the block is idle; it is clamped to
//   1..MAX_WIDTH. Every pixel at row >= 2 and column >= 2 yields a result on
//   res_out with the nine-pixel sum and the window's top-left row and column.
//   An end item yields one closing result with the count of complete rows
//   and size_error, and restarts the row and column counters.
// Timing:
//   One pixel per clock sustained while the output queue has room. A result
//   is offered once it is written into the output queue: the line store read
//   and the stage 1 registers capture the accepted pixel, and the column
//   adder then feeds the output queue.
//   Rate is set by the single read-modify-write of the line store RAM per
//   pixel, with write-to-read forwarding for back-to-back hits on a column.
// Reset and stall:
//   Reset clears counters, window, queue and sets the width to 3; the line
//   store contents stay undefined until written, no clearing pass. When the
//   receiver stalls, up to three results queue up; pix_in.ready drops once
//   the queue plus the item in flight fill it.
module box_sum_3x3_valid #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             image_width_we,
    input  logic [bs3_pkg::CFG_BITS-1:0]     image_width,
    bs3_pix_if.sink                          pix_in,
    bs3_res_if.source                        res_out
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int WB        = (CW + 1 > bs3_pkg::CFG_BITS) ? CW + 1 : bs3_pkg::CFG_BITS;
    localparam int COL_BITS  = PIXEL_BITS + 2;
    localparam int SUM_BITS  = PIXEL_BITS + 4;
    localparam int EXT_BITS  = (SUM_BITS > bs3_pkg::SUM_OUT_BITS) ? SUM_BITS
                                                                  : bs3_pkg::SUM_OUT_BITS;
    localparam int RB        = bs3_pkg::ROW_BITS;

    // Width register and effective width
    logic [bs3_pkg::CFG_BITS-1:0] image_width_reg;
    logic [WB-1:0]                w_raw;
    logic [WB-1:0]                w_eff;

    // Stage 0 counters
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RB-1:0] row_reg;
    logic [RB-1:0] row_next;
    logic          accept;
    logic          last_col;
    logic          emit0;

    // Stage 1 item
    logic                              s1_valid_reg;
    logic                              s1_end_reg;
    logic                              s1_emit_reg;
    logic [RB-1:0]                     s1_row_reg;
    logic [bs3_pkg::COL_OUT_BITS-1:0]  s1_col_reg;
    logic [CW-1:0]                     s1_addr_reg;
    logic [PIXEL_BITS-1:0]             s1_pix_reg;
    logic [RB-1:0]                     s1_rows_reg;
    logic                              s1_err_reg;

    // Line store data and window column sums
    logic [PIXEL_BITS-1:0]    ls_upper;
    logic [PIXEL_BITS-1:0]    ls_middle;
    logic signed [COL_BITS-1:0] col_sum;
    logic signed [COL_BITS-1:0] cs_old_reg;
    logic signed [COL_BITS-1:0] cs_new_reg;
    logic signed [SUM_BITS-1:0] win_sum;
    logic signed [EXT_BITS-1:0] win_ext;

    // Output queue
    bs3_pkg::result_t q_reg [bs3_pkg::QUEUE_DEPTH];
    bs3_pkg::result_t push_data;
    bs3_pkg::result_t head;
    logic [1:0]       wr_ptr_reg;
    logic [1:0]       rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    // Width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= bs3_pkg::WIDTH_DEFAULT;
        end
        else if (image_width_we)
        begin
            image_width_reg <= image_width;
        end
    end

    // Clamp width to 1..MAX_WIDTH
    always_comb
    begin
        w_raw = WB'(image_width_reg);
        if (w_raw == '0)
        begin
            w_eff = WB'(1);
        end
        else if (w_raw > WB'(MAX_WIDTH))
        begin
            w_eff = WB'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_raw;
        end
    end

    // Input handshake: room for the item in flight plus this one
    assign pix_in.ready = ({1'b0, count_reg} + {2'b00, s1_valid_reg}) <= 3'd2;
    assign accept       = pix_in.valid && pix_in.ready;

    // Column and row counters
    assign last_col = (WB'(col_reg) + WB'(1)) >= w_eff;
    assign emit0    = (row_reg >= RB'(2)) && (col_reg >= CW'(2));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_in.end_of_image)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (last_col)
        begin
            col_next = '0;
            if (row_reg != bs3_pkg::ROW_MAX)
            begin
                row_next = row_reg + RB'(1);
            end
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_end_reg  <= pix_in.end_of_image;
            s1_emit_reg <= emit0;
            s1_row_reg  <= row_reg - RB'(2);
            s1_col_reg  <= bs3_pkg::COL_OUT_BITS'(col_reg - CW'(2));
            s1_addr_reg <= col_reg;
            s1_pix_reg  <= pix_in.pixel_value;
            s1_rows_reg <= row_reg;
            s1_err_reg  <= (row_reg < bs3_pkg::MIN_ROWS) || (w_eff < WB'(3));
        end
    end

    // Line stores: read at acceptance, write back in stage 1
    bs3_line_store #(
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (CW),
        .DATA_BITS (PIXEL_BITS)
    ) u_line_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept && !pix_in.end_of_image),
        .rd_addr   (col_reg),
        .wr_en     (s1_valid_reg && !s1_end_reg),
        .wr_addr   (s1_addr_reg),
        .wr_upper  (ls_middle),
        .wr_middle (s1_pix_reg),
        .rd_upper  (ls_upper),
        .rd_middle (ls_middle)
    );

    // Current column sum and window sum
    assign col_sum = COL_BITS'(signed'(ls_upper)) + COL_BITS'(signed'(ls_middle))
                   + COL_BITS'(signed'(s1_pix_reg));
    assign win_sum = SUM_BITS'(col_sum) + SUM_BITS'(cs_new_reg) + SUM_BITS'(cs_old_reg);
    assign win_ext = EXT_BITS'(win_sum);

    // Window: the two previous column sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_old_reg <= '0;
            cs_new_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_end_reg)
            begin
                cs_old_reg <= '0;
                cs_new_reg <= '0;
            end
            else
            begin
                cs_old_reg <= cs_new_reg;
                cs_new_reg <= col_sum;
            end
        end
    end

    // Result record for the queue
    always_comb
    begin
        push_data = '0;
        if (s1_end_reg)
        begin
            push_data.done_res      = 1'b1;
            push_data.complete_rows = s1_rows_reg;
            push_data.size_error    = s1_err_reg;
        end
        else
        begin
            push_data.window_sum = win_ext[bs3_pkg::SUM_OUT_BITS-1:0];
            push_data.out_row    = s1_row_reg;
            push_data.out_col    = s1_col_reg;
        end
    end

    assign push = s1_valid_reg && (s1_end_reg || s1_emit_reg);
    assign pop  = res_out.valid && res_out.ready;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Queue pointers and fill level
    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == bs3_pkg::QUEUE_LAST) ? 2'd0 : wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == bs3_pkg::QUEUE_LAST) ? 2'd0 : rd_ptr_reg + 2'd1;
            end
        end
    end

    // Output channel
    assign head                  = q_reg[rd_ptr_reg];
    assign res_out.valid         = count_reg != 2'd0;
    assign res_out.window_sum    = head.window_sum;
    assign res_out.out_row       = head.out_row;
    assign res_out.out_col       = head.out_col;
    assign res_out.done_res      = head.done_res;
    assign res_out.complete_rows = head.complete_rows;
    assign res_out.size_error    = head.size_error;

endmodule

### bench/testbench.sv
// Self-checking bench for box_sum_3x3_valid: drives pixel and end transactions with random
// idling, predicts each 3x3 window sum and closing count, and checks every result field.
// Depends on bs3_pkg, bs3_if.sv (bs3_pix_if, bs3_res_if) and the box_sum_3x3_valid RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_W        = 1024;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned RANDOM_ITEMS = 560;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         image_width_we;
    logic [bs3_pkg::CFG_BITS-1:0] image_width;

    bs3_pix_if #(.PIXEL_BITS(16)) pix_if ();
    bs3_res_if                    res_if ();

    box_sum_3x3_valid #(
        .MAX_WIDTH  (MAX_W),
        .PIXEL_BITS (16)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .image_width_we (image_width_we),
        .image_width    (image_width),
        .pix_in         (pix_if),
        .res_out        (res_if)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Window predictor state
    logic [bs3_pkg::CFG_BITS-1:0] width_reg;
    logic signed [15:0]           upper_row [MAX_W];
    logic signed [15:0]           middle_row [MAX_W];
    logic signed [15:0]           win_cols [6];
    int unsigned                  col_pos;
    int unsigned                  row_pos;

    bs3_pkg::result_t pending_windows [$];
    bs3_pkg::result_t oldest_window;
    int unsigned      error_count;
    int unsigned      items_sent;
    int unsigned      results_seen;
    int unsigned      cycle_count;

    // Idling controls for the sender and the receiver process
    bit          tx_gaps_on;
    bit          rx_stalls_on;
    int unsigned hold_len;

    function automatic void clear_model();
        width_reg = bs3_pkg::WIDTH_DEFAULT;
        foreach (upper_row[i])
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        foreach (win_cols[i])
            win_cols[i] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Width register clamped to 1..MAX_W
    function automatic int unsigned active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_W)
            return MAX_W;
        return width_reg;
    endfunction

    // Advance the predictor by one accepted transaction, queue any result it yields
    function automatic void predict_window(input logic signed [15:0] pix, input logic eoi);
        bs3_pkg::result_t   r;
        int unsigned        w;
        int unsigned        c;
        logic signed [15:0] top;
        logic signed [15:0] mid;
        int                 acc;

        w = active_width();
        r = '0;
        if (eoi)
        begin
            r.done_res      = 1'b1;
            r.complete_rows = row_pos[bs3_pkg::ROW_BITS-1:0];
            r.size_error    = (row_pos < bs3_pkg::MIN_ROWS) || (w < 3);
            pending_windows.push_back(r);
            col_pos = 0;
            row_pos = 0;
            foreach (win_cols[i])
                win_cols[i] = '0;
        end
        else
        begin
            c   = (col_pos >= MAX_W) ? 0 : col_pos;
            top = upper_row[c];
            mid = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = pix;

            acc = top + mid + pix;
            for (int i = 0; i < 6; i++)
                acc += win_cols[i];

            // oldest column drops out, current column enters
            for (int i = 0; i < 3; i++)
                win_cols[i] = win_cols[i + 3];
            win_cols[3] = top;
            win_cols[4] = mid;
            win_cols[5] = pix;

            if (row_pos >= 2 && c >= 2)
            begin
                r.window_sum = acc[bs3_pkg::SUM_OUT_BITS-1:0];
                r.out_row    = bs3_pkg::ROW_BITS'(row_pos - 2);
                r.out_col    = bs3_pkg::COL_OUT_BITS'(c - 2);
                pending_windows.push_back(r);
            end

            if (c + 1 >= w)
            begin
                col_pos = 0;
                if (row_pos < bs3_pkg::ROW_MAX)
                    row_pos++;
            end
            else
                col_pos = c + 1;
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Offer one transaction, hold it until accepted, then maybe idle a burst
    task automatic send_item(input logic signed [15:0] pix, input logic eoi);
        pix_if.valid        <= 1'b1;
        pix_if.pixel_value  <= pix;
        pix_if.end_of_image <= eoi;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        predict_window(pix, eoi);
        items_sent++;
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic pix_stop();
        if (pix_if.valid)
            pix_if.valid <= 1'b0;
    endtask

    // Let all expected results come out, plus the pipeline depth for items without one
    task automatic drain();
        pix_stop();
        while (pending_windows.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_width(input logic [bs3_pkg::CFG_BITS-1:0] val);
        image_width_we <= 1'b1;
        image_width    <= val;
        @(posedge clk);
        image_width_we <= 1'b0;
        width_reg = val;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [bs3_pkg::CFG_BITS-1:0] pick_width();
        case ($urandom_range(0, 19))
            0: return bs3_pkg::CFG_BITS'($urandom_range(0, 2));
            1, 2: return bs3_pkg::CFG_BITS'($urandom_range(17, 64));
            3: return bs3_pkg::CFG_BITS'($urandom_range(65, 96));
            default: return bs3_pkg::CFG_BITS'($urandom_range(3, 16));
        endcase
    endfunction

    // Saturated all-max and all-min 3x3 images
    task automatic test_pixel_extremes();
        drain();
        write_width(bs3_pkg::WIDTH_DEFAULT);
        repeat (9) send_item(16'sh7FFF, 1'b0);
        send_item(16'sh0000, 1'b1);
        repeat (9) send_item(16'sh8000, 1'b0);
        send_item(16'sh7FFF, 1'b1);
    endtask

    // Images too narrow or too short, and widths outside the legal range
    task automatic test_size_errors();
        drain();
        write_width(11'd2);
        repeat (6) send_item(rand_pixel(), 1'b0);
        send_item(rand_pixel(), 1'b1);
        send_item(rand_pixel(), 1'b1);
        drain();
        write_width(11'd0);
        repeat (2) send_item(rand_pixel(), 1'b0);
        send_item(rand_pixel(), 1'b1);
        drain();
        write_width(11'd1);
        repeat (4) send_item(rand_pixel(), 1'b0);
        send_item(rand_pixel(), 1'b1);
        drain();
        write_width(11'd2047);
        repeat (MAX_W + 2) send_item(rand_pixel(), 1'b0);
        send_item(rand_pixel(), 1'b1);
        drain();
        write_width(bs3_pkg::WIDTH_DEFAULT);
        repeat (6) send_item(rand_pixel(), 1'b0);
        send_item(rand_pixel(), 1'b1);
    endtask

    // A last row cut short still yields its windows but is not counted
    task automatic test_short_final_row();
        drain();
        write_width(11'd4);
        repeat (3 * 4 + 3) send_item(rand_pixel(), 1'b0);
        send_item(rand_pixel(), 1'b1);
    endtask

    // Narrow the width past the column counter, then widen it within the columns
    // this image has already written
    task automatic test_width_change_mid_row();
        drain();
        write_width(11'd8);
        repeat (2 * 8 + 5) send_item(rand_pixel(), 1'b0);
        drain();
        write_width(11'd4);
        repeat (1 + 4) send_item(rand_pixel(), 1'b0);
        drain();
        write_width(11'd6);
        repeat (6) send_item(rand_pixel(), 1'b0);
        send_item(rand_pixel(), 1'b1);
    endtask

    // Random widths and image shapes; an image may run over several shapes before
    // it is closed, and it is always closed before the width changes
    task automatic test_random_images();
        int unsigned goal;
        int unsigned w;
        int unsigned rows;
        int unsigned tail;

        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            drain();
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            write_width(pick_width());
            w = active_width();
            repeat ($urandom_range(1, 3))
            begin
                if (items_sent < goal)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(rand_pixel(), 1'b1);
                    rows = (w > 64) ? $urandom_range(2, 3) : $urandom_range(0, 6);
                    tail = ($urandom_range(0, 2) == 0) ? $urandom_range(0, w - 1) : 0;
                    repeat (rows * w + tail) send_item(rand_pixel(), 1'b0);
                    if ($urandom_range(0, 5) != 0)
                        send_item(rand_pixel(), 1'b1);
                end
            end
            if (col_pos != 0 || row_pos != 0)
                send_item(rand_pixel(), 1'b1);
        end
    endtask

    // Receiver holds off long enough for the output queue to fill and stall the input
    task automatic test_backpressure();
        drain();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        write_width(11'd5);
        hold_len = 200;
        repeat (8 * 5) send_item(rand_pixel(), 1'b0);
        send_item(rand_pixel(), 1'b1);
    endtask

    // Receiver: random stall bursts, or a requested long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                res_if.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
                res_if.ready <= 1'b1;
            end
            else if (rx_stalls_on && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                res_if.ready <= 1'b1;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // Result checker: compare each accepted transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (pending_windows.size() == 0)
                flag_mismatch($sformatf("result %0d arrived with none expected", results_seen));
            else
            begin
                oldest_window = pending_windows.pop_front();
                if (res_if.window_sum !== oldest_window.window_sum)
                    flag_mismatch($sformatf("result %0d window_sum got %0d expected %0d",
                        results_seen, res_if.window_sum, oldest_window.window_sum));
                if (res_if.out_row !== oldest_window.out_row)
                    flag_mismatch($sformatf("result %0d out_row got %0d expected %0d",
                        results_seen, res_if.out_row, oldest_window.out_row));
                if (res_if.out_col !== oldest_window.out_col)
                    flag_mismatch($sformatf("result %0d out_col got %0d expected %0d",
                        results_seen, res_if.out_col, oldest_window.out_col));
                if (res_if.done_res !== oldest_window.done_res)
                    flag_mismatch($sformatf("result %0d done_res got %b expected %b",
                        results_seen, res_if.done_res, oldest_window.done_res));
                if (res_if.complete_rows !== oldest_window.complete_rows)
                    flag_mismatch($sformatf("result %0d complete_rows got %0d expected %0d",
                        results_seen, res_if.complete_rows, oldest_window.complete_rows));
                if (res_if.size_error !== oldest_window.size_error)
                    flag_mismatch($sformatf("result %0d size_error got %b expected %b",
                        results_seen, res_if.size_error, oldest_window.size_error));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        rst_n               <= 1'b0;
        image_width_we      <= 1'b0;
        image_width         <= bs3_pkg::WIDTH_DEFAULT;
        pix_if.valid        <= 1'b0;
        pix_if.pixel_value  <= '0;
        pix_if.end_of_image <= 1'b0;
        res_if.ready        <= 1'b0;
        error_count  = 0;
        items_sent   = 0;
        results_seen = 0;
        cycle_count  = 0;
        hold_len     = 0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        clear_model();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pixel_extremes();
        test_short_final_row();
        test_size_errors();
        test_width_change_mid_row();
        test_random_images();
        test_backpressure();

        drain();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

### files.f
rtl/core/bs3_pkg.sv
rtl/core/bs3_if.sv
rtl/core/bs3_line_store.sv
rtl/core/box_sum_3x3_valid.sv
bench/testbench.sv
